>>> rtl/wgm_pkg.sv
package wgm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = 5;
    localparam int CHAR_W      = 8;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT  = 2'd1;
    localparam logic [OP_W-1:0] OP_END   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE   = 1'd1;

    localparam logic [CHAR_W-1:0] STAR_CHAR     = 8'd42;
    localparam logic [CHAR_W-1:0] QUESTION_CHAR = 8'd63;
    localparam logic [CHAR_W-1:0] UPPER_A       = 8'd65;
    localparam logic [CHAR_W-1:0] UPPER_Z       = 8'd90;
    localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'd32;

    typedef logic [PATTERN_MAX:0]   t_set;
    typedef logic [PATTERN_MAX-1:0] t_stars;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic advance;    // text byte transfer: move the reach tokens
        logic restart;    // end of text: back to position zero
        logic case_fold;
    } t_cell_ctrl;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic fold_en);
        if (fold_en && c inside {[UPPER_A:UPPER_Z]}) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    // Star closure: a star at position j passes reach from j to j+1.
    // Same recurrence as a carry chain (generate = reach & star,
    // propagate = star), so it rides on one adder.
    function automatic t_set closure(input t_set s, input t_stars star,
                                     input logic [LEN_W-1:0] len);
        t_set                 sm;
        t_set                 stm;
        t_set                 gen;
        logic [PATTERN_MAX+1:0] sum;
        logic [PATTERN_MAX+1:0] carry;
        for (int j = 0; j <= PATTERN_MAX; j++) begin
            sm[j] = s[j] && (LEN_W'(j) <= len);
        end
        for (int j = 0; j < PATTERN_MAX; j++) begin
            stm[j] = star[j] && (LEN_W'(j) < len);
        end
        stm[PATTERN_MAX] = 1'b0;
        gen   = sm & stm;
        sum   = {1'b0, stm} + {1'b0, gen};
        carry = sum ^ {1'b0, stm} ^ {1'b0, gen};
        return sm | carry[PATTERN_MAX:0];
    endfunction

endpackage

>>> rtl/wildcard_glob_matcher.sv
// Channel  Dir  Handshake              Payload
// -------  ---  ---------------------  ------------------------------------
// in       in   i_in_valid/o_in_stall  i_operation, i_index, i_char_value
// out      out  o_out_valid/i_out_stall o_matched, o_no_hope
// cfg      in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle unless the sink stalls; results pass stage 1, then stage 2.
// Stage 1: star closure, token move, then a second closure of the moved set;
// those two closure adders in series set the cycle time. Stage 2: verdict.
// Reset (synchronous, active low) sets only position zero reachable,
// length 0, case folding on; pattern bytes are not cleared.
// A held result freezes the pipe; the input stalls only while it waits.
module wildcard_glob_matcher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [wgm_pkg::OP_W-1:0]          i_operation,
    input  logic [wgm_pkg::IDX_W-1:0]         i_index,
    input  logic [wgm_pkg::CHAR_W-1:0]        i_char_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_matched,
    output logic                              o_no_hope,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wgm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wgm_pkg::*;

    // configuration
    logic [LEN_W-1:0] r_len;      // already saturated to PATTERN_MAX
    logic             r_case;

    // pipeline control
    logic enable;
    logic acc;
    logic r_s1_valid;
    logic r_out_valid;

    // cell row
    t_cell_ctrl        ctrl;
    t_set              reach_vec;
    t_stars            star_vec;
    t_stars            handoff_vec;
    t_set              adv_vec;
    t_set              adv_cl;        // moved tokens after the star closure
    t_set              set0;
    logic [CHAR_W-1:0] text_f;
    logic              r_reach_end;   // position PATTERN_MAX
    logic              n_reach_end;

    // stage 1 payload: closed set for the verdict
    t_set   r_s1_set;

    logic r_matched;
    logic r_no_hope;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_case <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LENGTH: begin
                    if (i_cfg_data > CFG_DATA_W'(PATTERN_MAX)) begin
                        r_len <= LEN_W'(PATTERN_MAX);
                    end else begin
                        r_len <= LEN_W'(i_cfg_data);
                    end
                end
                CFG_CASE: r_case <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipe advances unless a finished result is held by the sink
    assign enable     = !r_out_valid || !i_out_stall;
    assign o_in_stall = !enable;
    assign acc        = i_in_valid && enable;

    assign ctrl.advance   = acc && (i_operation == OP_TEXT);
    assign ctrl.restart   = acc && (i_operation == OP_END);
    assign ctrl.case_fold = r_case;

    assign text_f = fold_char(i_char_value, r_case);

    // closure of the stored tokens with the stars as of this transfer
    assign set0 = closure(reach_vec, star_vec, r_len);

    // stored reach is kept closed under the stars seen by the text byte,
    // so a later rewrite of a star does not drop positions already reached
    assign adv_cl = closure(adv_vec, star_vec, r_len);

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        logic prev;
        if (i == 0) begin : g_first
            assign prev = 1'b0;
        end else begin : g_rest
            assign prev = handoff_vec[i-1];
        end

        wgm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_wr_en      (acc && (i_operation == OP_WRITE) &&
                           (i_index == IDX_W'(i))),
            .i_wr_char    (i_char_value),
            .i_text       (text_f),
            .i_active     (LEN_W'(i) < r_len),
            .i_closed     (set0[i]),
            .i_reach_prev (prev),
            .i_reach_next (adv_cl[i]),
            .i_init       (i == 0),
            .o_reach      (reach_vec[i]),
            .o_star       (star_vec[i]),
            .o_handoff    (handoff_vec[i]),
            .o_next_adv   (adv_vec[i])
        );
    end

    // last position has no pattern byte, it only receives tokens
    assign adv_vec[PATTERN_MAX]   = handoff_vec[PATTERN_MAX-1];
    assign reach_vec[PATTERN_MAX] = r_reach_end;

    always_comb begin
        n_reach_end = r_reach_end;
        if (ctrl.advance) begin
            n_reach_end = adv_cl[PATTERN_MAX];
        end else if (ctrl.restart) begin
            n_reach_end = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach_end <= 1'b0;
        end else begin
            r_reach_end <= n_reach_end;
        end
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (enable) begin
            r_s1_valid  <= acc;
            r_out_valid <= r_s1_valid;
        end
    end

    // stage 1: text byte -> moved and closed tokens, anything else -> closed tokens
    always_ff @(posedge i_clk) begin
        if (enable) begin
            r_s1_set <= ctrl.advance ? adv_cl : set0;
        end
    end

    // stage 2: verdict
    always_ff @(posedge i_clk) begin
        if (enable) begin
            r_matched <= r_s1_set[r_len];
            r_no_hope <= (r_s1_set == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_matched;
    assign o_no_hope   = r_no_hope;

    // a match always leaves at least one reachable position
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_matched && o_no_hope))
        else $error("matched and no_hope both set");

    // end of text leaves only position zero reachable
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(ctrl.restart) |-> (reach_vec == t_set'(1)))
        else $error("reach set not restarted after end of text");

    // stage 1 holds an item only if one was transferred when the pipe moved
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(enable) && r_s1_valid |-> $past(acc))
        else $error("stage 1 valid without an input transfer");

endmodule

>>> rtl/wgm_cell.sv
module wgm_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wgm_pkg::t_cell_ctrl            i_ctrl,
    input  logic                           i_wr_en,
    input  logic [wgm_pkg::CHAR_W-1:0]     i_wr_char,
    input  logic [wgm_pkg::CHAR_W-1:0]     i_text,
    input  logic                           i_active,
    input  logic                           i_closed,
    input  logic                           i_reach_prev,
    input  logic                           i_reach_next,
    input  logic                           i_init,
    output logic                           o_reach,
    output logic                           o_star,
    output logic                           o_handoff,
    output logic                           o_next_adv
);
    import wgm_pkg::*;

    logic [CHAR_W-1:0] r_char;
    logic              r_reach;
    logic              n_reach;
    logic              star_stored;
    logic              keep;

    assign star_stored = (r_char == STAR_CHAR);
    // a write in this transfer already counts for the closure
    assign o_star      = i_wr_en ? (i_wr_char == STAR_CHAR) : star_stored;

    assign keep      = i_closed && i_active && star_stored;
    assign o_handoff = i_closed && i_active && !star_stored &&
                       ((r_char == QUESTION_CHAR) ||
                        (fold_char(r_char, i_ctrl.case_fold) == i_text));
    assign o_next_adv = keep || i_reach_prev;
    assign o_reach    = r_reach;

    // moved token, closed again across the row, is what gets stored
    always_comb begin
        n_reach = r_reach;
        if (i_ctrl.advance) begin
            n_reach = i_reach_next;
        end else if (i_ctrl.restart) begin
            n_reach = i_init;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_char <= i_wr_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach <= i_init;
        end else begin
            r_reach <= n_reach;
        end
    end

endmodule

>>> tb/tb_top.sv
typedef struct packed {
    logic matched;
    logic no_hope;
} t_verdict;

// Scoreboard: tracks the reachable pattern positions and queues one verdict
// per accepted input transfer.
class glob_scoreboard;
    logic [wgm_pkg::CHAR_W-1:0] pat_bytes [wgm_pkg::PATTERN_MAX];
    wgm_pkg::t_set              reach;
    int unsigned                pat_len;
    bit                         fold_case;
    t_verdict                   verdicts [$];
    int unsigned                mismatches;

    function new();
        foreach (pat_bytes[i]) pat_bytes[i] = '0;
        reach      = wgm_pkg::t_set'(1);
        pat_len    = 0;
        fold_case  = 1'b1;
        mismatches = 0;
    endfunction

    function int unsigned live_len();
        return (pat_len > wgm_pkg::PATTERN_MAX) ? wgm_pkg::PATTERN_MAX : pat_len;
    endfunction

    function logic [wgm_pkg::CHAR_W-1:0] lower(logic [wgm_pkg::CHAR_W-1:0] c);
        if (fold_case && c >= wgm_pkg::UPPER_A && c <= wgm_pkg::UPPER_Z)
            return c + wgm_pkg::CASE_OFFSET;
        return c;
    endfunction

    // drop positions past the length, then let stars pass reach forward
    function wgm_pkg::t_set spread_stars(wgm_pkg::t_set s);
        wgm_pkg::t_set r;
        int unsigned   n;
        n = live_len();
        r = '0;
        for (int i = 0; i <= n; i++) r[i] = s[i];
        for (int i = 0; i < n; i++)
            if (r[i] && pat_bytes[i] == wgm_pkg::STAR_CHAR) r[i+1] = 1'b1;
        return r;
    endfunction

    function wgm_pkg::t_set consume(wgm_pkg::t_set s, logic [wgm_pkg::CHAR_W-1:0] ch);
        wgm_pkg::t_set nxt;
        int unsigned   n;
        n   = live_len();
        nxt = '0;
        for (int i = 0; i < n; i++) begin
            if (s[i]) begin
                if (pat_bytes[i] == wgm_pkg::STAR_CHAR)
                    nxt[i] = 1'b1;
                else if (pat_bytes[i] == wgm_pkg::QUESTION_CHAR ||
                         lower(pat_bytes[i]) == lower(ch))
                    nxt[i+1] = 1'b1;
            end
        end
        return nxt;
    endfunction

    function void set_register(logic [wgm_pkg::CFG_IDX_W-1:0] idx,
                               logic [wgm_pkg::CFG_DATA_W-1:0] data);
        if (idx == wgm_pkg::CFG_LENGTH)
            pat_len = 32'(data);
        else if (idx == wgm_pkg::CFG_CASE)
            fold_case = data[0];
    endfunction

    function void note_input(logic [wgm_pkg::OP_W-1:0] op,
                             logic [wgm_pkg::IDX_W-1:0] idx,
                             logic [wgm_pkg::CHAR_W-1:0] ch);
        wgm_pkg::t_set cur;
        t_verdict      v;
        if (op == wgm_pkg::OP_WRITE) pat_bytes[idx] = ch;
        cur = spread_stars(reach);
        if (op == wgm_pkg::OP_TEXT) begin
            cur   = spread_stars(consume(cur, ch));
            reach = cur;
        end
        v.matched = cur[live_len()];
        v.no_hope = (cur == '0);
        verdicts = {verdicts, v};
        if (op == wgm_pkg::OP_END) reach = wgm_pkg::t_set'(1);
    endfunction

    function int unsigned pending();
        return verdicts.size();
    endfunction

    task report_mismatch(string msg);
        $display("ERROR: %s", msg);
        mismatches++;
    endtask

    task check_result(logic m, logic nh);
        t_verdict v;
        if (verdicts.size() == 0) begin
            report_mismatch($sformatf("result with no verdict waiting: matched=%b no_hope=%b",
                                      m, nh));
        end else begin
            v = verdicts.pop_front();
            if (m !== v.matched)
                report_mismatch($sformatf("matched=%b, want %b", m, v.matched));
            if (nh !== v.no_hope)
                report_mismatch($sformatf("no_hope=%b, want %b", nh, v.no_hope));
        end
    endtask
endclass

module tb_top;
    import wgm_pkg::*;

    // opcode 3 is unused by the block; it must be ignored
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned     ITEM_GOAL = 1300;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_operation  = OP_WRITE;
    logic [IDX_W-1:0]      i_index      = '0;
    logic [CHAR_W-1:0]     i_char_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    logic                  o_matched;
    logic                  o_no_hope;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = CFG_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    glob_scoreboard sb = new();

    // sender-side view of the pattern, used to build matching text
    logic [CHAR_W-1:0] drv_pat [PATTERN_MAX];
    int unsigned       drv_len     = 0;
    bit                drv_fold    = 1'b1;
    logic [CHAR_W-1:0] text_q [$];
    int unsigned       items_sent  = 0;
    int unsigned       burst_left  = 0;

    // receiver stall pattern state
    logic [1:0]        stall_mode  = 2'd0;
    int unsigned       stall_timer = 0;

    wildcard_glob_matcher u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_index      (i_index),
        .i_char_value (i_char_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_matched    (o_matched),
        .o_no_hope    (o_no_hope),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Receiver back-pressure. The mode is redrawn whenever its timer runs out:
    // never stall, coin flip, mostly stalled, or a fixed 3-of-8 rhythm.
    always @(posedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode  <= 2'($urandom_range(0, 3));
            stall_timer <= $urandom_range(50, 400);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            2'd0:    i_out_stall <= 1'b0;
            2'd1:    i_out_stall <= 1'($urandom_range(0, 1));
            2'd2:    i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_timer[2:0] < 3'd3);
        endcase
    end

    // Monitors: sample pre-edge values, so every transfer is seen exactly
    // once, independent of process ordering within the time step.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                sb.note_input(i_operation, i_index, i_char_value);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_matched, o_no_hope);
        end
    end

    // Letter pool is small so patterns and text collide often.
    function automatic logic [CHAR_W-1:0] pick_letter();
        case ($urandom_range(0, 4))
            0:       return 8'h61;  // a
            1:       return 8'h62;  // b
            2:       return 8'h63;  // c
            3:       return 8'h41;  // A
            default: return 8'h42;  // B
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] noise_byte();
        if ($urandom_range(0, 1)) return pick_letter();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_pat_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) return STAR_CHAR;
        if (r < 35) return QUESTION_CHAR;
        if (r < 85) return pick_letter();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // A text byte that the given pattern byte accepts.
    function automatic logic [CHAR_W-1:0] text_for(logic [CHAR_W-1:0] p);
        logic [CHAR_W-1:0] up;
        up = p & ~CASE_OFFSET;
        if (p == QUESTION_CHAR) return CHAR_W'($urandom_range(0, 255));
        if (drv_fold && up >= UPPER_A && up <= UPPER_Z)
            return $urandom_range(0, 1) ? (up | CASE_OFFSET) : up;
        return p;
    endfunction

    // One input transfer. Bursts of random length, random gaps in between;
    // now and then a long burst with no gaps at all.
    task automatic send(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                        logic [CHAR_W-1:0] ch);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 20);
        end
        burst_left--;
        if (op == OP_WRITE) drv_pat[idx] = ch;
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_index      <= idx;
        i_char_value <= ch;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Hold off until every queued verdict has come back. The first edge
    // lets the monitor log the last transfer before we look at the queue.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Both registers back to back; valid drops once, after the second.
    task automatic write_config(int unsigned len, bit fold);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LENGTH;
        i_cfg_data  <= CFG_DATA_W'(len);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_CASE;
        i_cfg_data  <= CFG_DATA_W'(fold);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        drv_len  = (len > PATTERN_MAX) ? PATTERN_MAX : len;
        drv_fold = fold;
    endtask

    // A side transfer in mid text: the ignored opcode, or a pattern write
    // that takes effect for the rest of the string.
    task automatic side_item();
        if ($urandom_range(0, 1))
            send(OP_UNUSED, IDX_W'($urandom_range(0, 31)), CHAR_W'($urandom_range(0, 255)));
        else
            send(OP_WRITE, IDX_W'($urandom_range(0, 31)), pick_pat_byte());
    endtask

    // One text string plus its end marker. Mostly strings built to match
    // the pattern, the rest corrupted copies or plain noise.
    task automatic run_string();
        int unsigned kind;
        int unsigned pos;
        text_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            for (int i = 0; i < drv_len; i++) begin
                if (drv_pat[i] == STAR_CHAR)
                    repeat ($urandom_range(0, 3)) text_q = {text_q, noise_byte()};
                else
                    text_q = {text_q, text_for(drv_pat[i])};
            end
            if (kind >= 70) begin
                pos = $urandom_range(0, 2);
                if (pos == 0 || text_q.size() == 0)
                    text_q = {text_q, noise_byte()};
                else if (pos == 1)
                    text_q[$urandom_range(0, text_q.size() - 1)] = noise_byte();
                else
                    text_q.delete($urandom_range(0, text_q.size() - 1));
            end
        end else begin
            repeat ($urandom_range(0, 12)) text_q = {text_q, noise_byte()};
        end
        foreach (text_q[i]) begin
            if ($urandom_range(0, 39) == 0) side_item();
            send(OP_TEXT, IDX_W'($urandom_range(0, 31)), text_q[i]);
        end
        send(OP_END, IDX_W'($urandom_range(0, 31)), CHAR_W'($urandom_range(0, 255)));
    endtask

    // Load a fresh pattern over the positions the new length will read,
    // drain, then reprogram and stream a few strings.
    task automatic run_phase(int unsigned len, bit fold);
        int unsigned live;
        live = (len > PATTERN_MAX) ? PATTERN_MAX : len;
        for (int i = 0; i < live; i++)
            send(OP_WRITE, IDX_W'(i), pick_pat_byte());
        drain();
        write_config(len, fold);
        repeat ($urandom_range(2, 10)) run_string();
    endtask

    initial begin
        int unsigned phase;
        int unsigned len;
        bit          fold;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: empty pattern (length 0 after reset, folding on)
        send(OP_END,    5'd0,  8'h00);   // empty text vs empty pattern
        send(OP_TEXT,   5'd0,  8'h00);   // NUL is a normal byte: no hope left
        send(OP_UNUSED, 5'd31, 8'hFF);   // ignored, status only
        send(OP_END,    5'd31, 8'hFF);

        // pattern "A?*b<NUL>*", plus the top store entry
        send(OP_WRITE, 5'd0,  8'h41);
        send(OP_WRITE, 5'd1,  QUESTION_CHAR);
        send(OP_WRITE, 5'd2,  STAR_CHAR);
        send(OP_WRITE, 5'd3,  8'h62);
        send(OP_WRITE, 5'd4,  8'h00);
        send(OP_WRITE, 5'd5,  STAR_CHAR);
        send(OP_WRITE, 5'd31, 8'hFF);
        drain();
        write_config(6, 1'b1);

        // folded case, '?' on an upper letter, star run, trailing empty star
        send(OP_TEXT, 5'd0, 8'h61);
        send(OP_TEXT, 5'd0, 8'h5A);
        send(OP_TEXT, 5'd0, 8'h78);
        send(OP_TEXT, 5'd0, 8'h79);
        send(OP_TEXT, 5'd0, 8'h42);
        send(OP_TEXT, 5'd0, 8'h00);
        send(OP_END,  5'd0, 8'h00);
        // first byte misses the leading A, then a byte after hope is gone
        send(OP_TEXT, 5'd0, 8'h63);
        send(OP_TEXT, 5'd0, 8'h71);
        send(OP_END,  5'd0, 8'h00);

        // --- random phases: extremes of length first, then mostly short
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            case (phase)
                0: len = PATTERN_MAX;
                1: len = 0;
                2: len = 63;               // saturates to the store size
                3: len = 1;
                4: len = PATTERN_MAX + 1;
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        case ($urandom_range(0, 3))
                            0:       len = 0;
                            1:       len = 1;
                            2:       len = PATTERN_MAX;
                            default: len = 63;
                        endcase
                    end else begin
                        len = $urandom_range(1, 10);
                    end
                end
            endcase
            fold = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            run_phase(len, fold);
            phase++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d verdicts never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("PASS wildcard_glob_matcher");
        else
            $display("FAIL wildcard_glob_matcher");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #10000000;
        $display("FAIL wildcard_glob_matcher");
        $finish;
    end

endmodule
